// ----- sv/tcw_pkg.sv -----
// tcw_pkg: shared sizes, codes and the command type of the text console writer
// depends on nothing; imported by every module of the block
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [15:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0]  ATTR_RESET = 8'h07;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic              do_write;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              do_clear;
    logic [ADDR_W-1:0] clr_base;
    logic              do_read;
    logic [ADDR_W-1:0] raddr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_READ
  } b_state_t;

endpackage

// ----- sv/tcw_front.sv -----
// tcw_front: takes items, tracks cursor, attribute and top row, builds commands
// depends on tcw_pkg
module tcw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      in_func,
  input  logic [7:0]                in_char_code,
  input  logic [4:0]                in_read_row,
  input  logic [6:0]                in_read_col,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_data,
  output tcw_pkg::cmd_t             cmd
);
  import tcw_pkg::*;

  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [7:0]       attr_r;

  logic [COL_W:0]   col_n;
  logic [ROW_W:0]   row_n;
  logic [COL_W:0]   tab_col;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic [7:0]       wr_char;
  logic             wr_en;
  logic             read_ok;

  // logical row to physical row of the circular screen
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] r);
    logic [ROW_W:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  always_comb begin
    col_n   = {1'b0, cur_col_r};
    row_n   = {1'b0, cur_row_r};
    tab_col = ({1'b0, cur_col_r} | (COL_W+1)'(7)) + (COL_W+1)'(1);
    wr_en   = 1'b0;
    wr_col  = cur_col_r;
    wr_row  = cur_row_r;
    wr_char = in_char_code;
    unique case (in_char_code)
      CH_LF: begin
        col_n = '0;
        row_n = row_n + 1'b1;
      end
      CH_TAB: begin
        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end else begin
          col_n = tab_col;
        end
      end
      CH_CR: col_n = '0;
      CH_BS: begin
        if (cur_col_r != '0) begin
          col_n = col_n - 1'b1;
        end else if (cur_row_r != '0) begin
          col_n = (COL_W+1)'(COLUMNS - 1);
          row_n = row_n - 1'b1;
        end
        // the space goes where the cursor lands
        wr_en   = 1'b1;
        wr_col  = col_n[COL_W-1:0];
        wr_row  = row_n[ROW_W-1:0];
        wr_char = CH_SPACE;
      end
      default: begin
        wr_en = 1'b1;
        col_n = col_n + 1'b1;
        if (col_n >= (COL_W+1)'(COLUMNS)) begin
          col_n = '0;
          row_n = row_n + 1'b1;
        end
      end
    endcase

    read_ok = (in_read_row < ROW_W'(ROWS)) && (in_read_col < COL_W'(COLUMNS));

    cmd         = '0;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    top_nxt     = top_r;
    if (in_func == FUNC_PUT) begin
      cur_col_nxt  = col_n[COL_W-1:0];
      cur_row_nxt  = row_n[ROW_W-1:0];
      cmd.do_write = wr_en;
      cmd.waddr    = cell_addr(phys_row(top_r, wr_row), wr_col);
      cmd.wdata    = {attr_r, wr_char};
      // cursor fell off the bottom: old top row becomes the blank bottom row
      if (row_n > (ROW_W+1)'(ROWS - 1)) begin
        cur_row_nxt  = ROW_W'(ROWS - 1);
        cmd.do_clear = 1'b1;
        cmd.clr_base = cell_addr(top_r, '0);
        top_nxt      = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
      end
    end else begin
      cmd.do_read = read_ok;
      cmd.raddr   = cell_addr(phys_row(top_r, in_read_row), in_read_col);
    end
    cmd.cursor_col = cur_col_nxt;
    cmd.cursor_row = cur_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      top_r     <= '0;
      attr_r    <= ATTR_RESET;
    end else begin
      if (accept) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        top_r     <= top_nxt;
      end
      if (cfg_we) attr_r <= cfg_data;
    end
  end

endmodule

// ----- sv/tcw_queue.sv -----
// tcw_queue: short command queue between front and back
// depends on tcw_pkg
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output tcw_pkg::cmd_t     head_cmd,
  output tcw_pkg::q_stat_t  stat
);
  import tcw_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/tcw_back.sv -----
// tcw_back: owns the screen memory, runs writes, row clears and reads, drives results
// depends on tcw_pkg
module tcw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::cmd_t     head_cmd,
  input  tcw_pkg::q_stat_t  stat,
  output logic              pop,
  output logic              init_busy,
  output logic              out_strobe,
  output logic [6:0]        out_cursor_col,
  output logic [4:0]        out_cursor_row,
  output logic [7:0]        out_cell_char,
  output logic [7:0]        out_cell_attr
);
  import tcw_pkg::*;

  logic [15:0] screen_mem [CELLS];

  b_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [15:0]       rd_q_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;

  logic              strobe_r, strobe_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [7:0]        attr_r, attr_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head_cmd.waddr;
    mem_re     = 1'b0;
    strobe_nxt = 1'b0;
    col_nxt    = col_r;
    row_nxt    = row_r;
    char_nxt   = '0;
    attr_nxt   = '0;
    unique case (state_r)
      B_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head_cmd;
          mem_we  = head_cmd.do_write;
          if (head_cmd.do_clear) begin
            cnt_nxt   = '0;
            state_nxt = B_CLEAR;
          end else if (head_cmd.do_read) begin
            mem_re    = 1'b1;
            state_nxt = B_READ;
          end else begin
            strobe_nxt = 1'b1;
            col_nxt    = head_cmd.cursor_col;
            row_nxt    = head_cmd.cursor_row;
          end
        end
      end
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_r.clr_base + cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(COLUMNS - 1)) begin
          cnt_nxt    = '0;
          state_nxt  = B_IDLE;
          strobe_nxt = 1'b1;
          col_nxt    = cmd_r.cursor_col;
          row_nxt    = cmd_r.cursor_row;
        end
      end
      B_READ: begin
        state_nxt  = B_IDLE;
        strobe_nxt = 1'b1;
        col_nxt    = cmd_r.cursor_col;
        row_nxt    = cmd_r.cursor_row;
        char_nxt   = rd_q_r[7:0];
        attr_nxt   = rd_q_r[15:8];
      end
      default: state_nxt = B_INIT;
    endcase
  end

  // only item writes carry data; sweeps write the blank cell
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= (state_r == B_IDLE) ? head_cmd.wdata : BLANK_CELL;
    end
    if (mem_re) rd_q_r <= screen_mem[head_cmd.raddr];
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    char_r <= char_nxt;
    attr_r <= attr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_INIT;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign init_busy      = (state_r == B_INIT);
  assign out_strobe     = strobe_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_cell_char  = char_r;
  assign out_cell_attr  = attr_r;

endmodule

// ----- sv/text_console_character_writer_top.sv -----
// text_console_character_writer_top: 80x25 text screen with cursor, put and read items
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | start & !busy              | in_func in_char_code in_read_row in_read_col
//  result   | out_strobe, one cycle      | out_cursor_col out_cursor_row
//           |                            | out_cell_char out_cell_attr
//  config   | cfg_valid & cfg_ready      | cfg_data (text attribute)
//
// the front takes one item a cycle unless busy, high when the 4-deep queue is full
// the back does a put in B_IDLE, a read via B_READ (registered memory read port) and
// a put that scrolls via B_CLEAR (one cell of the new bottom row cleared per cycle)
// a result shows the cycle after the back is done with it; results may not be held off
// after reset a clearing pass writes all 2000 cells, one a cycle, with busy high
module text_console_character_writer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_func,
  input  logic [7:0] in_char_code,
  input  logic [4:0] in_read_row,
  input  logic [6:0] in_read_col,
  output logic       out_strobe,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import tcw_pkg::*;

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    accept;
  logic    pop;
  logic    init_busy;

  assign busy      = q_stat.full | init_busy;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  tcw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (front_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .stat           (q_stat),
    .pop            (pop),
    .init_busy      (init_busy),
    .out_strobe     (out_strobe),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !accept)
    else $error("item taken while queue full");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_cursor_col < COL_W'(COLUMNS)) && (out_cursor_row < ROW_W'(ROWS)))
    else $error("cursor off screen");

  a_no_result_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !pop && !out_strobe)
    else $error("activity during clearing pass");

endmodule
